/* rtl/irm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types, codes and constants of the ICMP reply matcher.
// ----------------------------------------------------------------------------
package irm_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_SEQ = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_TYPE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXCEED_TYPE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEND_TICK    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_IP    = 3'd5;

  localparam logic [7:0] EXCEED_TYPE_RST = 8'd11;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_OTHER    = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  typedef struct packed {
    logic [7:0]  pkt_byte;
    logic        pkt_last;
    logic [31:0] now_tick;
  } irm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reply_kind;
    logic [31:0] source_ip;
    logic [31:0] round_trip;
    logic        reached;
  } irm_out_t;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] expected_seq;
    logic [7:0]  echo_reply_type;
    logic [7:0]  exceeded_type;
    logic [31:0] send_tick;
    logic [31:0] target_ip;
  } irm_cfg_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [15:0] got_id;
    logic [15:0] got_seq;
    logic [7:0]  icmp_kind;
    logic        too_short;
    logic        fields_complete;
    logic [31:0] now_tick;
  } irm_rec_t;

endpackage
`default_nettype wire

/* rtl/irm_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irm_parser
// Walks the packet byte by byte, captures the source address, ICMP type,
// identifier and sequence, and emits one record on the last byte.
// ----------------------------------------------------------------------------
module irm_parser
  import irm_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire irm_cfg_t cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire irm_in_t  in_data,
  input  wire logic     rec_full,
  output logic          rec_push,
  output irm_rec_t      rec_data
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CMP_W = (IDX_W > 8) ? IDX_W : 8;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [5:0]       hlen_r, hlen_nxt;
  logic [5:0]       ilen_r, ilen_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [31:0]      src_r, src_nxt;
  logic             done_r, done_nxt;

  logic             take;
  logic             inner_ok;
  logic             accept;
  logic [7:0]       b;
  logic [CMP_W-1:0] ie;
  logic [CMP_W-1:0] he;
  logic [CMP_W-1:0] pe;

  assign in_ready = !rec_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.pkt_byte;
  assign take     = idx_r < IDX_W'(MAX_PACKET_BYTES);
  assign ie       = CMP_W'(idx_r);

  always_comb begin
    hlen_nxt = hlen_r;
    ilen_nxt = ilen_r;
    kind_nxt = kind_r;
    id_nxt   = id_r;
    seq_nxt  = seq_r;
    src_nxt  = src_r;
    done_nxt = done_r;
    idx_nxt  = idx_r;
    inner_ok = 1'b0;
    if (take && idx_r == '0) begin
      hlen_nxt = {b[3:0], 2'b00};
    end
    he = CMP_W'(hlen_nxt);
    pe = he + CMP_W'(8) + CMP_W'(ilen_r);
    if (take) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (ie >= CMP_W'(12) && ie <= CMP_W'(15)) begin
        src_nxt = {src_r[23:0], b};
      end
      if (ie == he) begin
        kind_nxt = b;
      end
      if (ie == he + CMP_W'(4)) id_nxt  = {b, 8'h00};
      if (ie == he + CMP_W'(5)) id_nxt  = {id_r[15:8], b};
      if (ie == he + CMP_W'(6)) seq_nxt = {b, 8'h00};
      if (ie == he + CMP_W'(7)) seq_nxt = {seq_r[15:8], b};
      inner_ok = (ie > he) && (kind_r == cfg.exceeded_type) &&
                 (kind_r != cfg.echo_reply_type);
      if (inner_ok) begin
        if (ie == he + CMP_W'(8)) ilen_nxt = {b[3:0], 2'b00};
        if (ie == pe + CMP_W'(4)) id_nxt  = {b, 8'h00};
        if (ie == pe + CMP_W'(5)) id_nxt  = {id_r[15:8], b};
        if (ie == pe + CMP_W'(6)) seq_nxt = {b, 8'h00};
        if (ie == pe + CMP_W'(7)) begin
          seq_nxt  = {seq_r[15:8], b};
          done_nxt = 1'b1;
        end
      end
    end
  end

  assign rec_push = accept && in_data.pkt_last;

  always_comb begin
    rec_data.src_addr        = src_nxt;
    rec_data.got_id          = id_nxt;
    rec_data.got_seq         = seq_nxt;
    rec_data.icmp_kind       = kind_nxt;
    rec_data.too_short       = CMP_W'(idx_nxt) < (he + CMP_W'(8));
    rec_data.fields_complete = done_nxt;
    rec_data.now_tick        = in_data.now_tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      idx_r  <= '0;
      hlen_r <= '0;
      ilen_r <= '0;
      kind_r <= '0;
      id_r   <= '0;
      seq_r  <= '0;
      src_r  <= '0;
      done_r <= 1'b0;
    end else if (accept) begin
      idx_r  <= idx_nxt;
      hlen_r <= hlen_nxt;
      ilen_r <= ilen_nxt;
      kind_r <= kind_nxt;
      id_r   <= id_nxt;
      seq_r  <= seq_nxt;
      src_r  <= src_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/irm_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irm_queue
// Short register queue of parsed packet records between parser and judge.
// ----------------------------------------------------------------------------
module irm_queue
  import irm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire irm_rec_t push_data,
  output logic          full,
  input  wire logic     pop,
  output irm_rec_t      pop_data,
  output logic          empty
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  irm_rec_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/irm_judge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irm_judge
// Turns a parsed record into a verdict and holds it in the output register.
// ----------------------------------------------------------------------------
module irm_judge
  import irm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire irm_cfg_t cfg,
  input  wire logic     rec_empty,
  input  wire irm_rec_t rec_data,
  output logic          rec_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output irm_out_t      out_data
);

  logic     out_valid_r;
  irm_out_t out_data_r, out_data_nxt;
  logic     match;

  assign rec_pop = !rec_empty && (!out_valid_r || out_ready);
  assign match   = (rec_data.got_id == cfg.expected_id) &&
                   (rec_data.got_seq == cfg.expected_seq);

  always_comb begin
    out_data_nxt.reply_kind = 1'b0;
    if (rec_data.too_short) begin
      out_data_nxt.status = ST_SHORT;
    end else if (rec_data.icmp_kind == cfg.echo_reply_type) begin
      out_data_nxt.status = match ? ST_OK : ST_MISMATCH;
    end else if (rec_data.icmp_kind == cfg.exceeded_type) begin
      out_data_nxt.reply_kind = 1'b1;
      if (!rec_data.fields_complete) begin
        out_data_nxt.status = ST_SHORT;
      end else begin
        out_data_nxt.status = match ? ST_OK : ST_MISMATCH;
      end
    end else begin
      out_data_nxt.status = ST_OTHER;
    end
    out_data_nxt.source_ip  = rec_data.src_addr;
    out_data_nxt.round_trip = rec_data.now_tick - cfg.send_tick;
    out_data_nxt.reached    = (out_data_nxt.status == ST_OK) &&
                              (rec_data.src_addr == cfg.target_ip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* rtl/icmp_reply_matcher_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_reply_matcher_top
// Matches received ICMP echo reply and time exceeded packets against the
// outstanding probe and reports one verdict per packet.
//
//   Channel  Direction  Handshake          Carries
//   in_      input      in_valid/in_ready  one packet byte, last flag, tick
//   out_     output     out_valid/out_ready one verdict per packet
//   cfg_     input      cfg_wr_en          register writes, no read-back
//
// One byte is taken per cycle. After the last byte the parser writes its
// record into the record queue, and the judge then registers the verdict
// into the output register. Reset is synchronous and clears the control
// and configuration registers to their defaults. The input stalls only
// when the record queue is full; a stalled output holds its verdict.
// ----------------------------------------------------------------------------
module icmp_reply_matcher_top
  import irm_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire irm_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output irm_out_t                    out_data,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  irm_cfg_t cfg_r;
  irm_rec_t push_data;
  irm_rec_t pop_data;
  logic     rec_push;
  logic     rec_pop;
  logic     rec_full;
  logic     rec_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id     <= '0;
      cfg_r.expected_seq    <= '0;
      cfg_r.echo_reply_type <= '0;
      cfg_r.exceeded_type   <= EXCEED_TYPE_RST;
      cfg_r.send_tick       <= '0;
      cfg_r.target_ip       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID:  cfg_r.expected_id     <= cfg_wdata[15:0];
        CFG_EXPECTED_SEQ: cfg_r.expected_seq    <= cfg_wdata[15:0];
        CFG_ECHO_TYPE:    cfg_r.echo_reply_type <= cfg_wdata[7:0];
        CFG_EXCEED_TYPE:  cfg_r.exceeded_type   <= cfg_wdata[7:0];
        CFG_SEND_TICK:    cfg_r.send_tick       <= cfg_wdata;
        CFG_TARGET_IP:    cfg_r.target_ip       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  irm_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec_data (push_data)
  );

  irm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (push_data),
    .full      (rec_full),
    .pop       (rec_pop),
    .pop_data  (pop_data),
    .empty     (rec_empty)
  );

  irm_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_empty (rec_empty),
    .rec_data  (pop_data),
    .rec_pop   (rec_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
